// File: rtl/core/prmt_pkg.sv
`default_nettype none
package prmt_pkg;
  localparam int MaxLeaves   = 1024;
  localparam int MaxVersions = 1024;
  localparam int PoolNodes   = 16384;
  localparam int ValueBits   = 32;

  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_UPDATE = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;
  localparam logic [1:0] KIND_NOP    = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_VER = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_BAD_IDX = 2'd3;

  // one classified item handed from the front to the back
  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [9:0]  index_a;
    logic [9:0]  index_b;
    logic [10:0] version;
    logic [63:0] value;
  } prmt_cmd_t;
endpackage
`default_nettype wire

// File: rtl/core/prmt_front.sv
`default_nettype none
module prmt_front #(
  parameter int MAX_LEAVES = prmt_pkg::MaxLeaves,
  parameter int VALUE_BITS = prmt_pkg::ValueBits
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_we,
  input  wire logic [10:0]             cfg_wdata,
  input  wire logic                    valid,
  output logic                         stall,
  input  wire logic [1:0]              kind,
  input  wire logic [9:0]              index_a,
  input  wire logic [9:0]              index_b,
  input  wire logic [10:0]             version,
  input  wire logic [VALUE_BITS-1:0]   value,
  output logic [10:0]                  leaves,
  output logic                         cmd_valid,
  input  wire logic                    cmd_stall,
  output prmt_pkg::prmt_cmd_t          cmd
);
  import prmt_pkg::*;
  localparam logic [10:0] LeavesMax = 11'(MAX_LEAVES > 1024 ? 1024 : MAX_LEAVES);

  // two-entry queue toward the back
  prmt_cmd_t q [2];
  logic [1:0] count;
  logic       rd_ptr, wr_ptr;
  logic       push, pop;
  prmt_cmd_t  c;

  assign stall = (count == 2'd2);
  assign push  = valid && !stall;
  assign pop   = cmd_valid && !cmd_stall;
  assign cmd_valid = (count != 2'd0);
  assign cmd = q[rd_ptr];

  // classify index errors; version checks depend on back state
  always_comb begin
    c = '0;
    c.kind = kind;
    c.index_a = index_a;
    c.index_b = index_b;
    c.version = version;
    c.value = 64'(value);
    c.status = ST_OK;
    if (kind == KIND_QUERY) begin
      if ({1'b0, index_a} >= leaves || {1'b0, index_b} >= leaves) c.status = ST_BAD_IDX;
    end else if (kind != KIND_NOP) begin
      if ({1'b0, index_a} >= leaves) c.status = ST_BAD_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      leaves <= LeavesMax;
      count <= '0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_wdata == 11'd0) leaves <= 11'd1;
        else if (cfg_wdata > LeavesMax) leaves <= LeavesMax;
        else leaves <= cfg_wdata;
      end
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
    if (push) q[wr_ptr] <= c;
  end
endmodule
`default_nettype wire

// File: rtl/core/prmt_back.sv
`default_nettype none
module prmt_back #(
  parameter int MAX_LEAVES   = prmt_pkg::MaxLeaves,
  parameter int MAX_VERSIONS = prmt_pkg::MaxVersions,
  parameter int POOL_NODES   = prmt_pkg::PoolNodes,
  parameter int VALUE_BITS   = prmt_pkg::ValueBits
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [10:0]           leaves,
  input  wire logic                  cmd_valid,
  output logic                       cmd_stall,
  input  wire prmt_pkg::prmt_cmd_t   cmd,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [VALUE_BITS-1:0]      min_value,
  output logic [1:0]                 status,
  output logic [10:0]                latest_version
);
  import prmt_pkg::*;
  localparam int NB  = $clog2(POOL_NODES);
  localparam int VB  = $clog2(MAX_VERSIONS + 1);
  localparam int LB  = (MAX_LEAVES > 1) ? $clog2(MAX_LEAVES) : 1;
  localparam int SPAN_I = 2 * (1 << LB);
  localparam int AREA_I = SPAN_I < POOL_NODES ? SPAN_I : POOL_NODES;
  localparam logic [NB:0] Area = (NB+1)'(AREA_I);
  localparam int SD  = LB + 2;
  localparam int SB  = $clog2(SD + 1);
  localparam int WB  = $clog2(SD*2 + 1);
  localparam logic [VALUE_BITS-1:0] VMax = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam int CLR = (POOL_NODES > MAX_VERSIONS + 1) ? POOL_NODES : MAX_VERSIONS + 1;
  localparam int CB  = $clog2(CLR + 1);

  // states
  localparam logic [4:0] S_CLEAR = 5'd0,  S_IDLE = 5'd1,  S_QPOP = 5'd2,  S_QRD = 5'd3,
                         S_QWAIT = 5'd4,  S_QEVAL = 5'd5, S_LDOWN = 5'd6, S_LDWAIT = 5'd7,
                         S_LUP = 5'd8,    S_LUPW = 5'd9,  S_LUPC = 5'd10, S_LUPC2 = 5'd11,
                         S_UROOT = 5'd12, S_URW = 5'd13,  S_UDOWN = 5'd14, S_UDW = 5'd15,
                         S_UBLD = 5'd16,  S_UBW = 5'd17,  S_UBC = 5'd18,   S_UBC2 = 5'd19,
                         S_DONE = 5'd20,  S_OUT = 5'd21,  S_CMIN = 5'd22;

  // node pool and version table; valid-by-clear pass after reset
  logic [VALUE_BITS-1:0] mem_min  [POOL_NODES];
  logic [NB-1:0]         mem_l    [POOL_NODES];
  logic [NB-1:0]         mem_r    [POOL_NODES];
  logic [NB-1:0]         mem_root [MAX_VERSIONS+1];

  logic [NB-1:0] ra, wa;
  logic          we_min, we_lnk;
  logic [VALUE_BITS-1:0] wmin, rd_min;
  logic [NB-1:0] wl, wr, rd_l, rd_r;
  logic [VB-1:0] rva, wva;
  logic          we_root;
  logic [NB-1:0] wroot, rd_root;

  always_ff @(posedge clk) begin
    if (we_min) mem_min[wa] <= wmin;
    if (we_lnk) begin
      mem_l[wa] <= wl;
      mem_r[wa] <= wr;
    end
    if (we_root) mem_root[wva] <= wroot;
    rd_min  <= mem_min[ra];
    rd_l    <= mem_l[ra];
    rd_r    <= mem_r[ra];
    rd_root <= mem_root[rva];
  end

  function automatic logic [VALUE_BITS-1:0] vmin(input logic [VALUE_BITS-1:0] a,
                                                 input logic [VALUE_BITS-1:0] b);
    return ($signed(a) <= $signed(b)) ? a : b;
  endfunction

  logic [4:0]    st;
  logic [CB-1:0] clr;
  prmt_cmd_t     c;
  prmt_cmd_t     cmd_in;
  logic [10:0]   vcount;
  logic [NB:0]   freep;
  logic          no_room;
  logic [VALUE_BITS-1:0] acc, tmp;
  // query work stack: node, interval
  logic [NB-1:0] wk_n [SD*2];
  logic [9:0]    wk_lo [SD*2];
  logic [9:0]    wk_hi [SD*2];
  logic [WB-1:0] wsp;
  logic [NB-1:0] cur;
  logic [9:0]    lo, hi, mid;
  // path stack for load and update
  logic [NB-1:0] ps_n [SD];
  logic          ps_d [SD];
  logic [SB-1:0] dep;
  logic [NB-1:0] child, pnode;
  logic [NB-1:0] kr;

  assign mid = 10'(({1'b0, lo} + {1'b0, hi}) >> 1);
  assign cmd_stall = (st != S_IDLE);
  assign latest_version = vcount;
  assign no_room = (vcount >= 11'(MAX_VERSIONS)) ||
                   ((NB+2)'(freep) + (NB+2)'(dep) + (NB+2)'(1) > (NB+2)'(POOL_NODES));

  // add the version checks that depend on back state
  always_comb begin
    cmd_in = cmd;
    if (cmd.status == ST_OK) begin
      if (cmd.kind == KIND_QUERY &&
          (cmd.version > vcount || cmd.version > 11'(MAX_VERSIONS))) begin
        cmd_in.status = ST_BAD_VER;
      end else if (cmd.kind == KIND_LOAD && vcount != 11'd0) begin
        cmd_in.status = ST_BAD_VER;
      end
    end
  end

  function automatic logic [NB-1:0] nd(input logic [NB-1:0] n);
    return ({1'b0, n} < (NB+1)'(POOL_NODES)) ? n : '0;
  endfunction

  // reset-image links for version-zero area
  function automatic logic [NB-1:0] rl(input logic [NB:0] k, input logic odd);
    logic [NB+1:0] cc;
    cc = {k, 1'b0} + (NB+2)'(odd);
    return (cc < (NB+2)'(AREA_I)) ? NB'(cc) : '0;
  endfunction

  always_comb begin
    we_min = 1'b0; we_lnk = 1'b0; we_root = 1'b0;
    wa = '0; wmin = VMax; wl = '0; wr = '0; wva = '0; wroot = '0;
    ra = cur; rva = '0;
    if (st == S_CLEAR) begin
      if ({1'b0, clr} < (CB+1)'(POOL_NODES)) begin
        we_min = 1'b1; we_lnk = 1'b1;
        wa = NB'(clr);
        wl = rl((NB+1)'(clr), 1'b0);
        wr = rl((NB+1)'(clr), 1'b1);
      end
      if ({1'b0, clr} < (CB+1)'(MAX_VERSIONS + 1)) begin
        we_root = 1'b1;
        wva = VB'(clr);
        wroot = (clr == '0) ? NB'(1) : '0;
      end
    end else if (st == S_QPOP || st == S_IDLE) begin
      rva = VB'(c.version);
    end else if (st == S_UROOT) begin
      rva = VB'(vcount);
    end
    if (st == S_LDWAIT && lo == hi) begin
      we_min = 1'b1; wa = cur; wmin = c.value[VALUE_BITS-1:0];
    end
    if (st == S_LUPC2) begin
      we_min = 1'b1; wa = pnode; wmin = vmin(tmp, rd_min);
    end
    if (st == S_UDW && lo == hi && !no_room) begin
      we_min = 1'b1; we_lnk = 1'b1; wa = NB'(freep);
      wmin = c.value[VALUE_BITS-1:0]; wl = rd_l; wr = rd_r;
    end
    if (st == S_UBW) begin
      we_lnk = 1'b1; wa = NB'(freep);
      wl = ps_d[dep-1'b1] ? rd_l : child;
      wr = ps_d[dep-1'b1] ? child : rd_r;
    end
    if (st == S_UBC2) begin
      we_min = 1'b1; wa = pnode; wmin = vmin(tmp, rd_min);
    end
    if (st == S_DONE && c.kind == KIND_UPDATE && c.status == ST_OK) begin
      we_root = 1'b1; wva = VB'(vcount + 11'd1); wroot = child;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_CLEAR;
      clr <= '0;
      vcount <= '0;
      freep <= Area;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && st != S_DONE) out_valid <= 1'b0;
      unique case (st)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == CB'(CLR - 1)) st <= S_IDLE;
        end
        S_IDLE: if (cmd_valid) begin
          c <= cmd_in;
          acc <= VMax;
          lo <= '0; hi <= 10'(leaves - 11'd1);
          dep <= '0;
          if (cmd_in.status != ST_OK || cmd_in.kind == KIND_NOP) st <= S_DONE;
          else if (cmd_in.kind == KIND_QUERY) begin
            if (cmd_in.index_a > cmd_in.index_b) st <= S_DONE;
            else st <= S_QPOP;
          end else if (cmd_in.kind == KIND_LOAD) begin
            cur <= NB'(1); st <= S_LDOWN;
          end else st <= S_UROOT;
        end
        // query: fetch root then walk pending subtrees
        S_QPOP: st <= S_QRD;
        S_QRD: begin
          cur <= nd(rd_root);
          wk_n[0] <= nd(rd_root); wk_lo[0] <= '0; wk_hi[0] <= 10'(leaves - 11'd1);
          wsp <= WB'(1);
          st <= S_QWAIT;
        end
        S_QWAIT: begin
          if (wsp == '0) st <= S_DONE;
          else begin
            cur <= nd(wk_n[wsp-1'b1]); lo <= wk_lo[wsp-1'b1]; hi <= wk_hi[wsp-1'b1];
            wsp <= wsp - 1'b1;
            st <= S_QEVAL;
          end
        end
        S_QEVAL: begin
          // memory read of cur lands this cycle; evaluate next cycle
          st <= S_OUT;
        end
        S_OUT: begin
          if (hi < c.index_a || c.index_b < lo) st <= S_QWAIT;
          else if (c.index_a <= lo && hi <= c.index_b) begin
            acc <= vmin(acc, rd_min); st <= S_QWAIT;
          end else begin
            wk_n[wsp] <= nd(rd_r); wk_lo[wsp] <= mid + 10'd1; wk_hi[wsp] <= hi;
            wk_n[wsp+1'b1] <= nd(rd_l); wk_lo[wsp+1'b1] <= lo; wk_hi[wsp+1'b1] <= mid;
            wsp <= wsp + 2'd2;
            st <= S_QWAIT;
          end
        end
        // load: descend heap, write leaf, refresh parents
        S_LDOWN: st <= S_LDWAIT;
        S_LDWAIT: begin
          if (lo == hi) st <= S_LUP;
          else begin
            ps_n[dep] <= cur; dep <= dep + 1'b1;
            if (c.index_a <= mid) begin cur <= nd(rd_l); hi <= mid; end
            else begin cur <= nd(rd_r); lo <= mid + 10'd1; end
            st <= S_LDOWN;
          end
        end
        S_LUP: begin
          if (dep == 0) st <= S_DONE;
          else begin
            pnode <= nd(ps_n[dep-1'b1]); cur <= nd(ps_n[dep-1'b1]); dep <= dep - 1'b1;
            st <= S_LUPW;
          end
        end
        S_LUPW: st <= S_LUPC;
        S_LUPC: begin
          kr <= nd(rd_r); cur <= nd(rd_l); st <= S_UBC;
        end
        // update: walk newest version, copy path
        S_UROOT: st <= S_URW;
        S_URW: begin
          cur <= (vcount <= 11'(MAX_VERSIONS)) ? nd(rd_root) : '0;
          st <= S_UDOWN;
        end
        S_UDOWN: st <= S_UDW;
        S_UDW: begin
          if (lo == hi) begin
            if (no_room) begin
              c.status <= ST_FULL; st <= S_DONE;
            end else begin
              child <= NB'(freep); freep <= freep + 1'b1;
              if (dep != 0) begin
                cur <= nd(ps_n[dep-1'b1]); st <= S_UBLD;
              end else st <= S_DONE;
            end
          end else begin
            ps_n[dep] <= cur; ps_d[dep] <= (c.index_a > mid); dep <= dep + 1'b1;
            if (c.index_a <= mid) begin cur <= nd(rd_l); hi <= mid; end
            else begin cur <= nd(rd_r); lo <= mid + 10'd1; end
            st <= S_UDOWN;
          end
        end
        S_UBLD: st <= S_UBW;
        S_UBW: begin
          // rd_l/rd_r now hold the old node's links; link the copy, then refresh it
          pnode <= NB'(freep);
          child <= NB'(freep);
          freep <= freep + 1'b1;
          dep <= dep - 1'b1;
          cur <= ps_d[dep-1'b1] ? nd(rd_l) : child;
          kr  <= ps_d[dep-1'b1] ? child : nd(rd_r);
          st <= S_UBC;
        end
        // parent refresh: read left minimum, then right, then write
        S_UBC: begin
          cur <= kr;
          st <= S_CMIN;
        end
        S_CMIN: begin
          tmp <= rd_min;
          st <= (c.kind == KIND_LOAD) ? S_LUPC2 : S_UBC2;
        end
        S_LUPC2: st <= S_LUP;
        S_UBC2: begin
          if (dep != 0) begin
            cur <= nd(ps_n[dep-1'b1]); st <= S_UBLD;
          end else st <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_stall == 1'b0) begin
            out_valid <= 1'b1;
            min_value <= (c.kind == KIND_QUERY && c.status == ST_OK) ? acc : VMax;
            status <= c.status;
            if (c.kind == KIND_UPDATE && c.status == ST_OK) vcount <= vcount + 11'd1;
            st <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/persistent_range_min_tree_unit.sv
`default_nettype none
// channel  | valid     | stall     | payload
// cfg      | cfg_we    | -         | cfg_wdata
// in       | in_valid  | in_stall  | kind index_a index_b version value
// out      | out_valid | out_stall | min_value status latest_version
// A query fetches the root, then for each visited node pops the work stack, reads the node
// and evaluates it; up to four nodes are visited on each of about eleven levels.
// Load: descend one level per node read, write the leaf, then refresh each parent on the path.
// Update: walk the newest version down, then copy each node of the path and refresh it.
// After reset a clearing pass over max(POOL_NODES, MAX_VERSIONS+1) entries runs first.
// Input stalls once the two-entry command queue is full; a stalled result holds the back.
module persistent_range_min_tree_unit #(
  parameter int MAX_LEAVES   = prmt_pkg::MaxLeaves,
  parameter int MAX_VERSIONS = prmt_pkg::MaxVersions,
  parameter int POOL_NODES   = prmt_pkg::PoolNodes,
  parameter int VALUE_BITS   = prmt_pkg::ValueBits
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [10:0]           cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [1:0]            kind,
  input  wire logic [9:0]            index_a,
  input  wire logic [9:0]            index_b,
  input  wire logic [10:0]           version,
  input  wire logic [VALUE_BITS-1:0] value,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [VALUE_BITS-1:0]      min_value,
  output logic [1:0]                 status,
  output logic [10:0]                latest_version
);
  import prmt_pkg::*;
  logic [10:0] leaves;
  logic        cmd_valid, cmd_stall;
  prmt_cmd_t   cmd;

  prmt_front #(.MAX_LEAVES(MAX_LEAVES), .VALUE_BITS(VALUE_BITS)) u_front (
    .clk, .rst, .cfg_we, .cfg_wdata, .valid(in_valid), .stall(in_stall),
    .kind, .index_a, .index_b, .version, .value, .leaves,
    .cmd_valid, .cmd_stall, .cmd
  );

  prmt_back #(.MAX_LEAVES(MAX_LEAVES), .MAX_VERSIONS(MAX_VERSIONS),
              .POOL_NODES(POOL_NODES), .VALUE_BITS(VALUE_BITS)) u_back (
    .clk, .rst, .leaves, .cmd_valid, .cmd_stall, .cmd,
    .out_valid, .out_stall, .min_value, .status, .latest_version
  );
endmodule
`default_nettype wire
